>>> rtl/tgi_pkg.sv
// Shared types and constants of the trilinear grid interpolator.
package tgi_pkg;

  // Width of one configuration register and of a coordinate
  localparam int unsigned COORD_W = 24;
  // Width of a table value and of the result
  localparam int unsigned VALUE_W = 32;
  // Width of a Q.16 axis weight, which spans 0 to 1.0 inclusive
  localparam int unsigned WEIGHT_W = 17;
  // Width of the flat entry index on the input port
  localparam int unsigned INDEX_W = 13;
  // Width of the register index on the configuration port
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_INV_STEP_X = 3'd3,
    REG_INV_STEP_Y = 3'd4,
    REG_INV_STEP_Z = 3'd5
  } cfg_reg_t;

  // Reset value of the inverse steps: 1.0 in Q8.16
  localparam logic [COORD_W-1:0] INV_STEP_ONE = 24'h01_0000;

  // Grid setup handed from the register bank to the front end
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] origin_z;
    logic [COORD_W-1:0] inv_step_x;
    logic [COORD_W-1:0] inv_step_y;
    logic [COORD_W-1:0] inv_step_z;
  } cfg_t;

endpackage

>>> rtl/trilinear_grid_interpolator.sv
// Top level of the trilinear grid interpolator.
//
// Input side is a queue: drive action and the payload with push; a beat is
// taken at a clock edge with push high and full low. action = 1 stores
// entry_value at flat index entry_index (indexes past the table are dropped)
// and yields no result; action = 0 looks up at pos_x/pos_y/pos_z and yields
// one interp_value. Results leave through a queue: the oldest result is shown
// while empty is low and is taken at an edge with pop high.
// The user does grid setup through cfg_write/cfg_index/cfg_data only while
// the block idles; the block does not enforce this. Throughput is one beat
// per cycle while full is low: eight table copies give all cell corners in a
// single read. The front end (3 stages) and back end (read plus 3 blend
// stages) each take queue space up front, so a stalled receiver fills the
// result queue, then the middle queue, and then raises full; no beat is lost.
// Reset clears the queues and pipelines and restores origins to 0 and inverse
// steps to 1.0. Table contents are undefined until written.
module trilinear_grid_interpolator #(
  parameter int unsigned POINTS_X = 32,
  parameter int unsigned POINTS_Y = 8,
  parameter int unsigned POINTS_Z = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 action,
  input  logic [tgi_pkg::COORD_W-1:0]          pos_x,
  input  logic [tgi_pkg::COORD_W-1:0]          pos_y,
  input  logic [tgi_pkg::COORD_W-1:0]          pos_z,
  input  logic [tgi_pkg::INDEX_W-1:0]          entry_index,
  input  logic signed [tgi_pkg::VALUE_W-1:0]   entry_value,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [tgi_pkg::VALUE_W-1:0]   interp_value,
  input  logic                                 cfg_write,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tgi_pkg::COORD_W-1:0]          cfg_data
);

  localparam int unsigned DEPTH     = POINTS_X * POINTS_Y * POINTS_Z;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned Q_W       = 1 + AW + tgi_pkg::VALUE_W + 3 * tgi_pkg::WEIGHT_W;

  // Register bank
  tgi_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.origin_z   <= '0;
      cfg.inv_step_x <= tgi_pkg::INV_STEP_ONE;
      cfg.inv_step_y <= tgi_pkg::INV_STEP_ONE;
      cfg.inv_step_z <= tgi_pkg::INV_STEP_ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        tgi_pkg::REG_ORIGIN_X:   cfg.origin_x   <= cfg_data;
        tgi_pkg::REG_ORIGIN_Y:   cfg.origin_y   <= cfg_data;
        tgi_pkg::REG_ORIGIN_Z:   cfg.origin_z   <= cfg_data;
        tgi_pkg::REG_INV_STEP_X: cfg.inv_step_x <= cfg_data;
        tgi_pkg::REG_INV_STEP_Y: cfg.inv_step_y <= cfg_data;
        tgi_pkg::REG_INV_STEP_Z: cfg.inv_step_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                           q_push, q_pop, q_empty;
  logic [Q_W-1:0]                 q_din, q_dout;
  logic [$clog2(Q_DEPTH+1)-1:0]   q_count;

  tgi_front #(
    .POINTS_X (POINTS_X),
    .POINTS_Y (POINTS_Y),
    .POINTS_Z (POINTS_Z),
    .AW       (AW),
    .Q_DEPTH  (Q_DEPTH),
    .Q_W      (Q_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .action      (action),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .full        (full),
    .q_push      (q_push),
    .q_data      (q_din),
    .q_count     (q_count)
  );

  // Queue between front and back
  tgi_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  tgi_back #(
    .POINTS_X  (POINTS_X),
    .POINTS_Y  (POINTS_Y),
    .POINTS_Z  (POINTS_Z),
    .AW        (AW),
    .OUT_DEPTH (OUT_DEPTH),
    .Q_W       (Q_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_dout),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .interp_value (interp_value)
  );

endmodule

>>> rtl/tgi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tgi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tgi_fifo.sv
// Small register queue with occupancy count.
module tgi_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  assign dout  = mem[rptr];
  assign empty = (count == '0);

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tgi_front.sv
// Front end: accepts beats, maps coordinates to cells and weights, forms addresses.
module tgi_front #(
  parameter int unsigned POINTS_X = 32,
  parameter int unsigned POINTS_Y = 8,
  parameter int unsigned POINTS_Z = 32,
  parameter int unsigned AW       = 13,
  parameter int unsigned Q_DEPTH  = 8,
  parameter int unsigned Q_W      = 1 + AW + 32 + 51
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tgi_pkg::cfg_t                      cfg,
  input  logic                               push,
  input  logic                               action,
  input  logic [tgi_pkg::COORD_W-1:0]        pos_x,
  input  logic [tgi_pkg::COORD_W-1:0]        pos_y,
  input  logic [tgi_pkg::COORD_W-1:0]        pos_z,
  input  logic [tgi_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [tgi_pkg::VALUE_W-1:0] entry_value,
  output logic                               full,
  output logic                               q_push,
  output logic [Q_W-1:0]                     q_data,
  input  logic [$clog2(Q_DEPTH+1)-1:0]       q_count
);

  localparam int unsigned DEPTH = POINTS_X * POINTS_Y * POINTS_Z;
  localparam int unsigned CXW = $clog2(POINTS_X);
  localparam int unsigned CYW = $clog2(POINTS_Y);
  localparam int unsigned CZW = $clog2(POINTS_Z);
  localparam int unsigned WW  = tgi_pkg::WEIGHT_W;
  localparam int unsigned VW  = tgi_pkg::VALUE_W;
  localparam int unsigned IW  = tgi_pkg::INDEX_W;
  localparam logic [25:0] TOP_X = 26'((POINTS_X - 1) * 65536);
  localparam logic [25:0] TOP_Y = 26'((POINTS_Y - 1) * 65536);
  localparam logic [25:0] TOP_Z = 26'((POINTS_Z - 1) * 65536);
  localparam logic [9:0]  CMAX_X = 10'(POINTS_X - 2);
  localparam logic [9:0]  CMAX_Y = 10'(POINTS_Y - 2);
  localparam logic [9:0]  CMAX_Z = 10'(POINTS_Z - 2);
  localparam int unsigned QCW = $clog2(Q_DEPTH+1);

  // Clamp a scaled position to the grid, pick the lower corner and its weight
  function automatic logic [26:0] locate(input logic [47:0] prod, input logic dpos,
                                         input logic [25:0] top, input logic [9:0] cmax);
    logic [31:0] p;
    logic [31:0] c;
    logic [31:0] w;
    p = dpos ? prod[47:16] : 32'd0;
    if (p > {6'd0, top}) begin
      p = {6'd0, top};
    end
    c = {16'd0, p[31:16]};
    if (c > {22'd0, cmax}) begin
      c = {22'd0, cmax};
    end
    w = p - {c[15:0], 16'd0};
    return {c[9:0], w[16:0]};
  endfunction

  // Stage 1: offset from origin and scale
  logic          s1_v, s1_wr, s1_wr_ok;
  logic [47:0]   s1_px, s1_py, s1_pz;
  logic          s1_dx, s1_dy, s1_dz;
  logic [IW-1:0] s1_idx;
  logic [VW-1:0] s1_val;
  logic [24:0]   dx, dy, dz;
  logic          accept;

  assign accept = push && !full;
  assign dx = {1'b0, pos_x} - {1'b0, cfg.origin_x};
  assign dy = {1'b0, pos_y} - {1'b0, cfg.origin_y};
  assign dz = {1'b0, pos_z} - {1'b0, cfg.origin_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
    s1_wr    <= action;
    s1_wr_ok <= (32'(entry_index) < 32'(DEPTH));
    s1_idx   <= entry_index;
    s1_val   <= entry_value;
    s1_px    <= dx[23:0] * cfg.inv_step_x;
    s1_py    <= dy[23:0] * cfg.inv_step_y;
    s1_pz    <= dz[23:0] * cfg.inv_step_z;
    s1_dx    <= !dx[24] && (dx != '0);
    s1_dy    <= !dy[24] && (dy != '0);
    s1_dz    <= !dz[24] && (dz != '0);
  end

  // Stage 2: clamp and split into cell and weight
  logic           s2_v, s2_wr, s2_wr_ok;
  logic [CXW-1:0] s2_cx;
  logic [CYW-1:0] s2_cy;
  logic [CZW-1:0] s2_cz;
  logic [WW-1:0]  s2_wx, s2_wy, s2_wz;
  logic [IW-1:0]  s2_idx;
  logic [VW-1:0]  s2_val;
  logic [26:0]    lx, ly, lz;

  assign lx = locate(s1_px, s1_dx, TOP_X, CMAX_X);
  assign ly = locate(s1_py, s1_dy, TOP_Y, CMAX_Y);
  assign lz = locate(s1_pz, s1_dz, TOP_Z, CMAX_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_wr    <= s1_wr;
    s2_wr_ok <= s1_wr_ok;
    s2_idx   <= s1_idx;
    s2_val   <= s1_val;
    s2_cx    <= CXW'(lx[26:17]);
    s2_cy    <= CYW'(ly[26:17]);
    s2_cz    <= CZW'(lz[26:17]);
    s2_wx    <= lx[16:0];
    s2_wy    <= ly[16:0];
    s2_wz    <= lz[16:0];
  end

  // Stage 3: row index along the two slow axes
  logic           s3_v, s3_wr, s3_wr_ok;
  logic [AW-1:0]  s3_row;
  logic [CZW-1:0] s3_cz;
  logic [WW-1:0]  s3_wx, s3_wy, s3_wz;
  logic [IW-1:0]  s3_idx;
  logic [VW-1:0]  s3_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_wr    <= s2_wr;
    s3_wr_ok <= s2_wr_ok;
    s3_idx   <= s2_idx;
    s3_val   <= s2_val;
    s3_row   <= AW'(32'(s2_cx) * 32'(POINTS_Y) + 32'(s2_cy));
    s3_cz    <= s2_cz;
    s3_wx    <= s2_wx;
    s3_wy    <= s2_wy;
    s3_wz    <= s2_wz;
  end

  // Form the base address and hand the beat to the queue; drop bad writes
  logic [AW-1:0] addr;

  assign addr   = s3_wr ? AW'(s3_idx)
                        : AW'(32'(s3_row) * 32'(POINTS_Z) + 32'(s3_cz));
  assign q_push = s3_v && (!s3_wr || s3_wr_ok);
  assign q_data = {s3_wr, addr, s3_val, s3_wx, s3_wy, s3_wz};

  // Hold off input while queue space is promised to beats in flight
  logic [QCW:0] used;

  assign used = {1'b0, q_count} + (QCW+1)'(s1_v) + (QCW+1)'(s2_v) + (QCW+1)'(s3_v);
  assign full = (used >= (QCW+1)'(Q_DEPTH));

endmodule

>>> rtl/tgi_back.sv
// Back end: table writes, eight corner reads and the three blend stages.
module tgi_back #(
  parameter int unsigned POINTS_X  = 32,
  parameter int unsigned POINTS_Y  = 8,
  parameter int unsigned POINTS_Z  = 32,
  parameter int unsigned AW        = 13,
  parameter int unsigned OUT_DEPTH = 8,
  parameter int unsigned Q_W       = 1 + AW + 32 + 51
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  logic [Q_W-1:0]                     q_data,
  output logic                               q_pop,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [tgi_pkg::VALUE_W-1:0] interp_value
);

  localparam int unsigned DEPTH = POINTS_X * POINTS_Y * POINTS_Z;
  localparam int unsigned WW    = tgi_pkg::WEIGHT_W;
  localparam int unsigned VW    = tgi_pkg::VALUE_W;
  localparam int unsigned OCW   = $clog2(OUT_DEPTH+1);

  // (b - a) * w, exact
  function automatic logic signed [50:0] mulw(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b,
                                              input logic [WW-1:0] w);
    logic signed [32:0] diff;
    diff = $signed({b[31], b}) - $signed({a[31], a});
    return diff * $signed({1'b0, w});
  endfunction

  // a + (b - a) * w, rounded half up back to Q8.24
  function automatic logic [VW-1:0] rnd(input logic [VW-1:0] a,
                                        input logic signed [50:0] prod);
    logic [50:0] s;
    s = {{3{a[31]}}, a, 16'd0} + prod + 51'd32768;
    return s[47:16];
  endfunction

  // Unpack the queue beat
  logic          q_wr;
  logic [AW-1:0] q_addr;
  logic [VW-1:0] q_val;
  logic [WW-1:0] q_wx, q_wy, q_wz;

  assign {q_wr, q_addr, q_val, q_wx, q_wy, q_wz} = q_data;

  // Take a beat only when the result queue has a slot for everything in flight
  logic          b1_v, b2_v, b3_v, b4_v;
  logic [OCW-1:0] out_count;
  logic [OCW:0]   used;

  assign used  = {1'b0, out_count} + (OCW+1)'(b1_v) + (OCW+1)'(b2_v)
               + (OCW+1)'(b3_v) + (OCW+1)'(b4_v);
  assign q_pop = !q_empty && (used < (OCW+1)'(OUT_DEPTH));

  // One table copy per cell corner, each read once per beat
  logic [VW-1:0] rd [8];

  for (genvar g = 0; g < 8; g++) begin : g_bank
    localparam int unsigned OFF = ((g >> 2) & 1) * POINTS_Y * POINTS_Z
                                + ((g >> 1) & 1) * POINTS_Z + (g & 1);
    tgi_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (q_pop && q_wr),
      .waddr (q_addr),
      .wdata (q_val),
      .raddr (q_addr + AW'(OFF)),
      .rdata (rd[g])
    );
  end

  // Stage 1: weights travel with the read data
  logic [WW-1:0] b1_wx, b1_wy, b1_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else begin
      b1_v <= q_pop && !q_wr;
    end
    b1_wx <= q_wx;
    b1_wy <= q_wy;
    b1_wz <= q_wz;
  end

  // Stage 2: products along z
  logic signed [50:0] b2_p [4];
  logic [VW-1:0]      b2_a [4];
  logic [WW-1:0]      b2_wx, b2_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else begin
      b2_v <= b1_v;
    end
    for (int l = 0; l < 4; l++) begin
      b2_p[l] <= mulw(rd[2*l], rd[2*l+1], b1_wz);
      b2_a[l] <= rd[2*l];
    end
    b2_wx <= b1_wx;
    b2_wy <= b1_wy;
  end

  // Stage 3: round z blends, products along y
  logic [VW-1:0]      zv [4];
  logic signed [50:0] b3_p [2];
  logic [VW-1:0]      b3_a [2];
  logic [WW-1:0]      b3_wx;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      zv[l] = rnd(b2_a[l], b2_p[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else begin
      b3_v <= b2_v;
    end
    b3_p[0] <= mulw(zv[0], zv[1], b2_wy);
    b3_p[1] <= mulw(zv[2], zv[3], b2_wy);
    b3_a[0] <= zv[0];
    b3_a[1] <= zv[2];
    b3_wx   <= b2_wx;
  end

  // Stage 4: round y blends, product along x
  logic [VW-1:0]      yv0, yv1;
  logic signed [50:0] b4_p;
  logic [VW-1:0]      b4_a;

  assign yv0 = rnd(b3_a[0], b3_p[0]);
  assign yv1 = rnd(b3_a[1], b3_p[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_v <= 1'b0;
    end else begin
      b4_v <= b3_v;
    end
    b4_p <= mulw(yv0, yv1, b3_wx);
    b4_a <= yv0;
  end

  // Round the final blend into the result queue
  logic [VW-1:0] res;

  assign res = rnd(b4_a, b4_p);

  tgi_fifo #(
    .WIDTH (VW),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (b4_v),
    .din   (res),
    .pop   (pop && !empty),
    .dout  (interp_value),
    .empty (empty),
    .count (out_count)
  );

endmodule

>>> rtl/tgi_checker.sv
// Port-level checks of the trilinear grid interpolator, bound to the top level.
module tgi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               push,
  input logic                               full,
  input logic                               action,
  input logic [tgi_pkg::COORD_W-1:0]        pos_x,
  input logic [tgi_pkg::COORD_W-1:0]        pos_y,
  input logic [tgi_pkg::COORD_W-1:0]        pos_z,
  input logic [tgi_pkg::INDEX_W-1:0]        entry_index,
  input logic signed [tgi_pkg::VALUE_W-1:0] entry_value,
  input logic                               empty,
  input logic                               pop,
  input logic signed [tgi_pkg::VALUE_W-1:0] interp_value,
  input logic                               cfg_write,
  input logic [tgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [tgi_pkg::COORD_W-1:0]        cfg_data
);

  // Reset drains the result queue
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Reset frees all input space
  a_rst_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // No result can appear the cycle after an idle reset-released block
  a_no_early: assert property (@(posedge clk) rst ##1 !rst |=> empty)
    else $error("result appeared too early after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(interp_value))
    else $error("waiting result changed without pop");

endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (.*);
